/* hdl/ist_pkg.sv */
// Shared types and codes for the interval set table.
// Holds operation and status codes and the controller to datapath interface.
// No dependencies.
package ist_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic walk;
    logic flush;
    logic finish;
  } ist_cmd_t;

  typedef struct packed {
    logic bypass;
    logic need_walk;
    logic last_entry;
    logic flush_more;
  } ist_sts_t;

  typedef struct packed {
    logic       covered;
    logic [1:0] status;
    logic [4:0] interval_count;
  } ist_res_t;

endpackage

/* hdl/ist_ctrl.sv */
// Controller of the interval set table: sequences load, table walk, flush and finish.
// Depends on ist_pkg for the command and status structs.
module ist_ctrl import ist_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_free,
  input  ist_sts_t sts,
  output logic     in_ready,
  output ist_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.bypass) begin
            state_next = S_DONE;
          end else if (sts.need_walk) begin
            state_next = S_WALK;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.last_entry) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (!sts.flush_more) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/ist_dp.sv */
// Datapath of the interval set table: two table banks, walk registers and merge logic.
// The old table is read from one bank while the new one is written to the other.
// Depends on ist_pkg for codes and the command, status and result structs.
module ist_dp import ist_pkg::*; #(
  parameter int MaxIntervals = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ist_cmd_t    cmd,
  input  logic [1:0]  func,
  input  logic [31:0] range_lo,
  input  logic [31:0] range_hi,
  output ist_sts_t    sts,
  output ist_res_t    res
);

  localparam int IW = $clog2(MaxIntervals);
  localparam int CW = $clog2(MaxIntervals + 2);

  logic [31:0] mem_s [2][MaxIntervals];
  logic [31:0] mem_e [2][MaxIntervals];
  logic [31:0] rd_s [2];
  logic [31:0] rd_e [2];

  logic [1:0]    op;
  logic          empty;
  logic [31:0]   lo, hi, lo_next, hi_next;
  logic          placed, placed_next;
  logic          hit, hit_next;
  logic [IW-1:0] idx, rd_addr;
  logic [CW-1:0] k, count, count_after;
  logic          bank_sel;
  logic          pend_valid, pend_valid_next;
  logic [31:0]   pend_s, pend_e, pend_s_next, pend_e_next;

  logic [31:0] s, e;
  logic        n1_v, n2_v;
  logic [31:0] n1_s, n1_e, n2_s, n2_e;
  logic        w_v, wr_en;
  logic [31:0] w_s, w_e;
  logic        full, commit;
  logic [31:0] count_ext;

  assign rd_addr = cmd.walk ? idx + IW'(1) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_s[~bank_sel][k[IW-1:0]] <= w_s;
      mem_e[~bank_sel][k[IW-1:0]] <= w_e;
    end
    rd_s[0] <= mem_s[0][rd_addr];
    rd_e[0] <= mem_e[0][rd_addr];
    rd_s[1] <= mem_s[1][rd_addr];
    rd_e[1] <= mem_e[1][rd_addr];
  end

  assign s = bank_sel ? rd_s[1] : rd_s[0];
  assign e = bank_sel ? rd_e[1] : rd_e[0];

  always_comb begin
    n1_v = 1'b0;
    n1_s = s;
    n1_e = e;
    n2_v = 1'b0;
    n2_s = s;
    n2_e = e;
    lo_next = lo;
    hi_next = hi;
    placed_next = placed;
    hit_next = hit;
    if (cmd.walk) begin
      case (op)
        FUNC_ADD: begin
          if (!placed && s > hi) begin
            n1_v = 1'b1;
            n1_s = lo;
            n1_e = hi;
            n2_v = 1'b1;
            placed_next = 1'b1;
          end else if (placed || e < lo) begin
            n1_v = 1'b1;
          end else begin
            if (s < lo) lo_next = s;
            if (e > hi) hi_next = e;
          end
        end
        FUNC_REMOVE: begin
          if (e <= lo || s >= hi) begin
            n1_v = 1'b1;
          end else begin
            n1_v = (s < lo) || (e > hi);
            n2_v = (s < lo) && (e > hi);
            n2_s = hi;
            if (s < lo) begin
              n1_e = lo;
            end else begin
              n1_s = hi;
            end
          end
        end
        FUNC_QUERY: begin
          if (s <= lo && e >= hi) hit_next = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.flush) begin
      if (op == FUNC_ADD && !placed) begin
        n1_v = 1'b1;
        n1_s = lo;
        n1_e = hi;
        placed_next = 1'b1;
      end
    end
  end

  always_comb begin
    if (pend_valid) begin
      w_v = 1'b1;
      w_s = pend_s;
      w_e = pend_e;
      pend_valid_next = n1_v;
      pend_s_next = n1_s;
      pend_e_next = n1_e;
    end else begin
      w_v = n1_v;
      w_s = n1_s;
      w_e = n1_e;
      pend_valid_next = n2_v;
      pend_s_next = n2_s;
      pend_e_next = n2_e;
    end
  end

  assign wr_en = w_v && (k < CW'(MaxIntervals));

  assign full   = k > CW'(MaxIntervals);
  assign commit = (op == FUNC_ADD || op == FUNC_REMOVE) && !empty && !full;
  assign count_after = commit ? k : count;
  assign count_ext = 32'(count_after);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_sel   <= 1'b0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        op     <= func;
        empty  <= (func != FUNC_NONE) && (range_lo >= range_hi);
        lo     <= range_lo;
        hi     <= range_hi;
        placed <= 1'b0;
        hit    <= 1'b0;
        idx    <= '0;
        k      <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.walk || cmd.flush) begin
        lo     <= lo_next;
        hi     <= hi_next;
        placed <= placed_next;
        hit    <= hit_next;
        k      <= k + CW'(w_v);
        pend_valid <= pend_valid_next;
        pend_s <= pend_s_next;
        pend_e <= pend_e_next;
        if (cmd.walk) idx <= idx + IW'(1);
      end
      if (cmd.finish && commit) begin
        bank_sel <= ~bank_sel;
        count    <= k;
      end
    end
  end

  always_comb begin
    sts.bypass     = (func == FUNC_NONE) || (range_lo >= range_hi) ||
                     ((count == '0) && (func != FUNC_ADD));
    sts.need_walk  = (count != '0);
    sts.last_entry = (CW'(idx) == count - CW'(1));
    sts.flush_more = pend_valid_next || (op == FUNC_ADD && !placed_next);
  end

  always_comb begin
    res.covered = (op == FUNC_QUERY) && !empty && hit;
    if (empty) begin
      res.status = ST_EMPTY;
    end else if ((op == FUNC_ADD || op == FUNC_REMOVE) && full) begin
      res.status = ST_FULL;
    end else begin
      res.status = ST_OK;
    end
    res.interval_count = count_ext[4:0];
  end

endmodule

/* hdl/interval_set_table.sv */
// Top level of the interval set table: controller, datapath and result register.
// Depends on ist_pkg, ist_ctrl and ist_dp.
//
// Keeps a sorted table of disjoint half-open intervals [lo, hi) over 32-bit
// coordinates. Each input item carries func (add, remove, query) and a range.
// Each item yields exactly one result item with covered, status and the
// number of stored intervals after the operation.
// Both channels use valid and ready. in_ready is high only while no item is
// in progress. An item with an empty range or an unused func code, and a
// remove or query on an empty table, skips the walk and the flush. Other
// items walk the stored table one entry per cycle on the single read port
// of the current bank. The new table is built in the other bank and takes
// effect by a bank swap, so a refused operation leaves the table unchanged.
// The result register holds a result until out_ready; the next item may be
// accepted meanwhile, and its finish waits until the register is free.
// Reset empties the table at once and clears out_valid and the pending entry.
module interval_set_table import ist_pkg::*; #(
  parameter int MAX_INTERVALS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] range_lo,
  input  logic [31:0] range_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        covered,
  output logic [1:0]  status,
  output logic [4:0]  interval_count
);

  ist_cmd_t cmd;
  ist_sts_t sts;
  ist_res_t res;
  logic     out_free;

  assign out_free = !out_valid || out_ready;

  ist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ist_dp #(
    .MaxIntervals (MAX_INTERVALS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .func     (func),
    .range_lo (range_lo),
    .range_hi (range_hi),
    .sts      (sts),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      covered        <= res.covered;
      status         <= res.status;
      interval_count <= res.interval_count;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Block accepted an item while another was in progress.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && covered) |-> (status == ST_OK))
    else $error("Covered result carries a non-ok status.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(interval_count) <= MAX_INTERVALS))
    else $error("Reported interval count exceeds the table capacity.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("Result was dropped before it was taken.");
`endif

endmodule
